// ===== rtl/core/ffn_pkg.sv =====
// ----------------------------------------------------------------------------
// ffn_pkg
// Shared types and constants for the flat-field normalize block: parameter
// defaults, output select codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ffn_pkg;

	// Parameter defaults
	localparam int COUNT_BITS_DEF      = 24;
	localparam int RATIO_FRAC_BITS_DEF = 16;
	localparam int MAX_PIXELS_DEF      = 1048576;

	// Result select codes
	typedef logic [1:0] ffn_osel_t;
	localparam ffn_osel_t OSEL_PASS = 2'd0;  // count passes through
	localparam ffn_osel_t OSEL_SAT  = 2'd1;  // saturated result
	localparam ffn_osel_t OSEL_QUOT = 2'd2;  // divider quotient

	// Controller to datapath commands
	typedef struct packed {
		logic      load;        // capture word, update count sum
		logic      ratio_init;  // set up divider for count/flat
		logic      mul_init;    // clear product registers
		logic      mul_step;    // one shift-add step of both products
		logic      form;        // build rounded numerator and denominator
		logic      div_init;    // set up divider for the correction
		logic      div_step;    // one restoring division step
		logic      ratio_acc;   // add quotient into ratio sum
		logic      out_load;    // write output register
		ffn_osel_t out_sel;
	} ffn_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_apply;    // captured word is an apply word
		logic flat_zero;   // captured flat value is zero
		logic ratio_zero;  // ratio sum is zero
		logic ovf;         // quotient will not fit in the count range
	} ffn_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffn_datapath.sv =====
// ----------------------------------------------------------------------------
// ffn_datapath
// Running sums, shift-add multipliers for numerator and denominator, shared
// radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffn_datapath
	import ffn_pkg::*;
#(
	parameter int COUNT_BITS      = COUNT_BITS_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
	parameter int MAX_PIXELS      = MAX_PIXELS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ffn_cmd_t              cmd,
	output      ffn_sts_t              sts,
	input  wire logic                  command,
	input  wire logic [COUNT_BITS-1:0] pixel_count,
	input  wire logic [COUNT_BITS-1:0] flat_value,
	input  wire logic                  frame_start,
	output      logic [COUNT_BITS-1:0] corrected_count,
	output      logic                  saturated
);

	localparam int PIX_BITS = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 0;
	localparam int SC_W     = COUNT_BITS + PIX_BITS;       // count sum
	localparam int SR_W     = SC_W + RATIO_FRAC_BITS;      // ratio sum
	localparam int PD_W     = SR_W + COUNT_BITS;           // ratio sum * flat
	localparam int DEN_W    = PD_W + 1;                    // doubled denominator
	localparam int NUM_W    = PD_W + 2;                    // rounded numerator
	localparam int Q_W      = COUNT_BITS + RATIO_FRAC_BITS;

	logic                  apply_q;
	logic [COUNT_BITS-1:0] op_a_q;
	logic [COUNT_BITS-1:0] op_b_q;
	logic [SC_W-1:0]       sum_counts_q;
	logic [SR_W-1:0]       sum_ratios_q;
	logic [NUM_W-1:0]      num_q;
	logic [DEN_W-1:0]      den_q;
	logic [DEN_W-1:0]      rem_q;
	logic [Q_W-1:0]        sh_q;
	logic [Q_W-1:0]        quo_q;

	logic [SC_W-1:0]       sc_base;
	logic [SC_W:0]         sc_sum;
	logic [SR_W:0]         sr_sum;
	logic [DEN_W:0]        rem_sh;
	logic [DEN_W:0]        rem_diff;
	logic                  rem_ge;

	// Saturating adders for the two sums
	assign sc_base = frame_start ? '0 : sum_counts_q;
	assign sc_sum  = {1'b0, sc_base} + (SC_W+1)'(pixel_count);
	assign sr_sum  = {1'b0, sum_ratios_q} + (SR_W+1)'(quo_q);

	// Running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_counts_q <= '0;
			sum_ratios_q <= '0;
		end else if (cmd.load && !command) begin
			sum_counts_q <= sc_sum[SC_W] ? '1 : sc_sum[SC_W-1:0];
			if (frame_start) begin
				sum_ratios_q <= '0;
			end
		end else if (cmd.ratio_acc) begin
			sum_ratios_q <= sr_sum[SR_W] ? '1 : sr_sum[SR_W-1:0];
		end
	end

	// Captured word; operands shift out MSB first while multiplying
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			apply_q <= command;
			op_a_q  <= pixel_count;
			op_b_q  <= flat_value;
		end else if (cmd.mul_step) begin
			op_a_q <= op_a_q << 1;
			op_b_q <= op_b_q << 1;
		end
	end

	// Divider step: shift in one numerator bit, subtract if it fits
	assign rem_sh   = {rem_q, sh_q[Q_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign rem_ge   = (rem_sh >= {1'b0, den_q});

	// Products, rounding, divider
	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			num_q <= '0;
			den_q <= '0;
		end else if (cmd.mul_step) begin
			num_q <= (num_q << 1) + (op_a_q[COUNT_BITS-1] ? NUM_W'(sum_counts_q) : '0);
			den_q <= (den_q << 1) + (op_b_q[COUNT_BITS-1] ? DEN_W'(sum_ratios_q) : '0);
		end else if (cmd.form) begin
			// 2*N*2^F + D over 2*D rounds half up
			num_q <= (num_q << (RATIO_FRAC_BITS + 1)) + NUM_W'(den_q);
			den_q <= den_q << 1;
		end else if (cmd.ratio_init) begin
			den_q <= DEN_W'(op_b_q);
		end

		if (cmd.ratio_init) begin
			rem_q <= '0;
			sh_q  <= {op_a_q, {RATIO_FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end else if (cmd.div_init) begin
			// high part is below the divisor once overflow is ruled out
			rem_q <= DEN_W'(num_q >> COUNT_BITS);
			sh_q  <= {num_q[COUNT_BITS-1:0], {RATIO_FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			sh_q  <= sh_q << 1;
			quo_q <= {quo_q[Q_W-2:0], rem_ge};
		end
	end

	// Status
	assign sts.is_apply   = apply_q;
	assign sts.flat_zero  = (op_b_q == '0);
	assign sts.ratio_zero = (sum_ratios_q == '0);
	assign sts.ovf        = ((num_q >> COUNT_BITS) >= NUM_W'(den_q));

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				OSEL_PASS: begin
					corrected_count <= op_a_q;
					saturated       <= 1'b0;
				end
				OSEL_QUOT: begin
					corrected_count <= quo_q[COUNT_BITS-1:0];
					saturated       <= 1'b0;
				end
				default: begin
					corrected_count <= '1;
					saturated       <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ffn_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffn_ctrl
// Sequencer for the flat-field normalize block: accepts one word at a time,
// steps the multipliers and divider, and owns the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ffn_ctrl
	import ffn_pkg::*;
#(
	parameter int COUNT_BITS      = COUNT_BITS_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output      logic     in_stall,
	output      logic     out_valid,
	input  wire logic     out_stall,
	input  wire ffn_sts_t sts,
	output      ffn_cmd_t cmd
);

	localparam int CNT_W = $clog2(COUNT_BITS + RATIO_FRAC_BITS + 1);
	localparam logic [CNT_W-1:0] RATIO_STEPS = CNT_W'(COUNT_BITS + RATIO_FRAC_BITS);
	localparam logic [CNT_W-1:0] COUNT_STEPS = CNT_W'(COUNT_BITS);
	localparam logic [CNT_W-1:0] LAST_STEP   = CNT_W'(1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_FORM   = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_DIV    = 3'd5;
	localparam logic [2:0] S_RACC   = 3'd6;
	localparam logic [2:0] S_RESULT = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	ffn_osel_t        osel_q, osel_d;
	logic             out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		cnt_d       = cnt_q;
		osel_d      = osel_q;
		cmd.out_sel = osel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.is_apply) begin
					if (sts.flat_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.ratio_init = 1'b1;
						cnt_d          = RATIO_STEPS;
						state_d        = S_DIV;
					end
				end else if (sts.flat_zero) begin
					osel_d  = OSEL_PASS;
					state_d = S_RESULT;
				end else if (sts.ratio_zero) begin
					osel_d  = OSEL_SAT;
					state_d = S_RESULT;
				end else begin
					cmd.mul_init = 1'b1;
					cnt_d        = COUNT_STEPS;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q - LAST_STEP;
				if (cnt_q == LAST_STEP) begin
					state_d = S_FORM;
				end
			end
			S_FORM: begin
				cmd.form = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				if (sts.ovf) begin
					osel_d  = OSEL_SAT;
					state_d = S_RESULT;
				end else begin
					cmd.div_init = 1'b1;
					cnt_d        = COUNT_STEPS;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - LAST_STEP;
				if (cnt_q == LAST_STEP) begin
					if (sts.is_apply) begin
						osel_d  = OSEL_QUOT;
						state_d = S_RESULT;
					end else begin
						state_d = S_RACC;
					end
				end
			end
			S_RACC: begin
				cmd.ratio_acc = 1'b1;
				state_d       = S_IDLE;
			end
			S_RESULT: begin
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			osel_q      <= OSEL_PASS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			osel_q  <= osel_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/flat_field_normalize.sv =====
// ----------------------------------------------------------------------------
// flat_field_normalize
// Two-pass flat-field correction of one image layer.
// ----------------------------------------------------------------------------
// The block takes one word at a time. An accumulate word (command 0) adds the
// count to a saturating count sum and, for a nonzero flat value, the truncated
// Q.RATIO_FRAC_BITS ratio count/flat to a saturating ratio sum; frame_start
// clears both sums first. It produces no result; the ratio comes from a
// radix-2 restoring divider that retires one quotient bit per cycle, and is
// skipped when the flat value is zero. An apply word (command 1) produces one
// result word: round half up of sum_counts*count*2^F/(sum_ratios*flat). The
// two products are formed by shift-add, overflow of the count range is found
// by one compare, and the same divider then retires COUNT_BITS quotient bits.
// A zero flat value passes the count through and a zero ratio sum saturates.
// Overflow and a zero denominator give all ones with saturated set.
// A finished result sits in an output register, so a new word is taken
// while the previous result is still stalled downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_field_normalize
	import ffn_pkg::*;
#(
	parameter int COUNT_BITS      = COUNT_BITS_DEF,
	parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF,
	parameter int MAX_PIXELS      = MAX_PIXELS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic                  command,
	input  wire logic [COUNT_BITS-1:0] pixel_count,
	input  wire logic [COUNT_BITS-1:0] flat_value,
	input  wire logic                  frame_start,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [COUNT_BITS-1:0] corrected_count,
	output      logic                  saturated
);

	ffn_cmd_t cmd;
	ffn_sts_t sts;

	// Sequencer
	ffn_ctrl #(
		.COUNT_BITS      (COUNT_BITS),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Sums, multipliers, divider, output register
	ffn_datapath #(
		.COUNT_BITS      (COUNT_BITS),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS),
		.MAX_PIXELS      (MAX_PIXELS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.command         (command),
		.pixel_count     (pixel_count),
		.flat_value      (flat_value),
		.frame_start     (frame_start),
		.corrected_count (corrected_count),
		.saturated       (saturated)
	);

	// Datapath commands never overlap
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.ratio_init, cmd.mul_init, cmd.mul_step, cmd.form,
			cmd.div_init, cmd.div_step, cmd.ratio_acc, cmd.out_load}))
		else $error("overlapping datapath commands");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("output register overwritten while stalled");

	// One word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while previous word in progress");

endmodule

`default_nettype wire

// ===== dv/tb_flat_field_normalize.sv =====
// ----------------------------------------------------------------------------
// tb_flat_field_normalize
// Self-checking bench for the two-pass flat-field correction block.
// ----------------------------------------------------------------------------
// Words go in through a valid/stall sender and are mirrored into a local
// model of the count and ratio sums. Every apply word pushes its corrected
// count onto a queue, and a monitor pops it against each word leaving the
// block. Directed tests cover empty sums, full-scale fields, exact halves in
// the rounding, a quotient on the count maximum and a zero ratio sum. Random
// frames then run (accumulate then apply) with random content, followed by
// pure noise. Both ends idle at random, and a watchdog ends a run that hangs.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flat_field_normalize;
	timeunit 1ns;
	timeprecision 1ps;

	import ffn_pkg::*;

	localparam int CB             = COUNT_BITS_DEF;
	localparam int FB             = RATIO_FRAC_BITS_DEF;
	localparam int COUNT_SUM_BITS = 44;
	localparam int RATIO_SUM_BITS = 60;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int MAX_SHOWN      = 10;

	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_APPLY = 1'b1;

	localparam logic [CB-1:0] COUNT_MAX     = '1;
	localparam logic [63:0]   COUNT_SUM_MAX = (64'd1 << COUNT_SUM_BITS) - 64'd1;
	localparam logic [63:0]   RATIO_SUM_MAX = (64'd1 << RATIO_SUM_BITS) - 64'd1;

	typedef struct packed {
		logic          cmd;
		logic [CB-1:0] count;
		logic [CB-1:0] flat;
		logic          start;
	} pixel_word_t;

	typedef struct packed {
		logic [CB-1:0] count;
		logic          sat;
	} corr_t;

	// DUT signals
	logic          clk             = 1'b0;
	logic          arst_n          = 1'b0;
	logic          in_valid        = 1'b0;
	logic          in_stall;
	logic          command         = CMD_ACCUM;
	logic [CB-1:0] pixel_count     = '0;
	logic [CB-1:0] flat_value      = '0;
	logic          frame_start     = 1'b0;
	logic          out_valid;
	logic          out_stall       = 1'b0;
	logic [CB-1:0] corrected_count;
	logic          saturated;

	// Model state and scoreboard
	logic [COUNT_SUM_BITS-1:0] count_sum = '0;
	logic [RATIO_SUM_BITS-1:0] ratio_sum = '0;
	corr_t                     corrected_q[$];
	int                        fail_count  = 0;
	int                        idle_cycles = 0;
	int                        gap_pct     = 0;
	int                        stall_pct   = 0;
	int                        stall_left  = 0;

	flat_field_normalize i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.pixel_count    (pixel_count),
		.flat_value     (flat_value),
		.frame_start    (frame_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.corrected_count(corrected_count),
		.saturated      (saturated)
	);

	always #6 clk = ~clk;

	// Idle length: mostly short, now and then long
	function automatic int burst_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	// Field value spread over zero, full scale and every magnitude
	function automatic logic [CB-1:0] rand_field();
		case ($urandom_range(7))
			0: return '0;
			1: return COUNT_MAX;
			2, 3: return CB'($urandom);
			default: return CB'($urandom) >> $urandom_range(CB - 1);
		endcase
	endfunction

	// Flat value around a frame's typical level
	function automatic logic [CB-1:0] flat_near(input logic [CB-1:0] level);
		return level - (level >> 2) + CB'($urandom_range(32'(level >> 1)));
	endfunction

	// Mirror one accepted word into the sums or the expected results
	task automatic predict_correction(input pixel_word_t w);
		logic [63:0]  acc;
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] quo;
		corr_t        res;
		if (w.cmd == CMD_ACCUM) begin
			if (w.start) begin
				count_sum = '0;
				ratio_sum = '0;
			end
			acc = 64'(count_sum) + 64'(w.count);
			count_sum = (acc > COUNT_SUM_MAX) ? '1 : acc[COUNT_SUM_BITS-1:0];
			if (w.flat != '0) begin
				acc = (64'(w.count) << FB) / 64'(w.flat);
				acc = acc + 64'(ratio_sum);
				ratio_sum = (acc > RATIO_SUM_MAX) ? '1 : acc[RATIO_SUM_BITS-1:0];
			end
		end else begin
			if (w.flat == '0) begin
				res.count = w.count;
				res.sat   = 1'b0;
			end else if (ratio_sum == '0) begin
				res.count = COUNT_MAX;
				res.sat   = 1'b1;
			end else begin
				// round half up: floor((2*N*2^F + D) / (2*D))
				num = 128'(count_sum) * 128'(w.count);
				den = 128'(ratio_sum) * 128'(w.flat);
				num = (num << (FB + 1)) + den;
				quo = num / (den << 1);
				if (quo > 128'(COUNT_MAX)) begin
					res.count = COUNT_MAX;
					res.sat   = 1'b1;
				end else begin
					res.count = quo[CB-1:0];
					res.sat   = 1'b0;
				end
			end
			corrected_q.insert(corrected_q.size(), res);
		end
	endtask

	// Drive one word and hold it until the block takes it
	task automatic send_word(input logic cmd, input logic [CB-1:0] count,
			input logic [CB-1:0] flat, input logic start);
		int          gap;
		pixel_word_t w;
		gap = ($urandom_range(99) < gap_pct) ? burst_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		pixel_count <= count;
		flat_value  <= flat;
		frame_start <= start;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		w.cmd   = cmd;
		w.count = count;
		w.flat  = flat;
		w.start = start;
		predict_correction(w);
	endtask

	task automatic set_idling();
		if ($urandom_range(3) == 0) begin
			gap_pct   = 0;
			stall_pct = 0;
		end else begin
			gap_pct   = $urandom_range(60, 5);
			stall_pct = $urandom_range(60, 5);
		end
	endtask

	// Apply before any accumulate: zero sums, pass-through, ignored frame start
	task automatic test_empty_sums();
		gap_pct   = 30;
		stall_pct = 30;
		send_word(CMD_APPLY, 24'd1000, 24'd7, 1'b0);
		send_word(CMD_APPLY, COUNT_MAX, '0, 1'b0);
		send_word(CMD_APPLY, '0, '0, 1'b1);
		send_word(CMD_APPLY, 24'd5, COUNT_MAX, 1'b1);
	endtask

	// Full-scale and zero fields on both passes
	task automatic test_extremes();
		gap_pct   = 0;
		stall_pct = 0;
		send_word(CMD_ACCUM, COUNT_MAX, COUNT_MAX, 1'b1);
		send_word(CMD_ACCUM, '0, 24'd1, 1'b0);
		send_word(CMD_ACCUM, COUNT_MAX, 24'd1, 1'b0);
		send_word(CMD_APPLY, COUNT_MAX, COUNT_MAX, 1'b0);
		send_word(CMD_APPLY, '0, COUNT_MAX, 1'b0);
		send_word(CMD_APPLY, 24'd1, 24'd1, 1'b0);
		send_word(CMD_APPLY, COUNT_MAX, '0, 1'b0);
		send_word(CMD_APPLY, 24'h5A5A5A, 24'hA5A5A5, 1'b1);
		send_word(CMD_APPLY, 24'h5A5A5A, 24'hA5A5A5, 1'b0);
	endtask

	// Exact halves, a quotient on the count maximum, ratio sum left at zero
	task automatic test_rounding_and_saturation();
		gap_pct   = 20;
		stall_pct = 50;
		// ratio 0.5 per count: 1/(0.5*4) is exactly a half
		send_word(CMD_ACCUM, 24'd1, 24'd2, 1'b1);
		send_word(CMD_APPLY, 24'd1, 24'd4, 1'b0);
		send_word(CMD_APPLY, 24'd3, 24'd4, 1'b0);
		// ratio sum of 1.0: full-scale apply lands exactly on the count maximum
		send_word(CMD_ACCUM, 24'd1, 24'd65536, 1'b1);
		send_word(CMD_APPLY, COUNT_MAX, 24'd1, 1'b0);
		// only zero flats, then a ratio truncated to zero
		send_word(CMD_ACCUM, 24'd5, '0, 1'b1);
		send_word(CMD_APPLY, 24'd3, 24'd7, 1'b0);
		send_word(CMD_ACCUM, 24'd1, COUNT_MAX, 1'b1);
		send_word(CMD_APPLY, 24'd3, 24'd7, 1'b0);
	endtask

	// Frames: a run of accumulate words, then apply words on the same level
	task automatic test_random_frames(input int n_items);
		int            sent;
		int            n_acc;
		int            n_app;
		logic [CB-1:0] level;
		sent = 0;
		while (sent < n_items) begin
			set_idling();
			level = rand_field() | CB'(1);
			n_acc = $urandom_range(12, 1);
			n_app = $urandom_range(8, 1);
			for (int i = 0; i < n_acc; i++)
				send_word(CMD_ACCUM, rand_field(),
					($urandom_range(9) == 0) ? '0 : flat_near(level),
					(i == 0) && ($urandom_range(4) != 0));
			for (int i = 0; i < n_app; i++)
				send_word(CMD_APPLY, rand_field(),
					($urandom_range(9) == 0) ? '0 : flat_near(level),
					$urandom_range(7) == 0);
			sent += n_acc + n_app;
		end
	endtask

	// Unstructured words
	task automatic test_random_noise(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0)
				set_idling();
			send_word(1'($urandom), rand_field(), rand_field(), 1'($urandom));
		end
	endtask

	// Downstream stall
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left <= burst_len() - 1;
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		corr_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (corrected_q.size() == 0) begin
				if (fail_count < MAX_SHOWN)
					$display("%0t: unexpected result count %0d sat %0b",
						$realtime, corrected_count, saturated);
				fail_count++;
			end else begin
				want = corrected_q.pop_front();
				if (corrected_count !== want.count || saturated !== want.sat) begin
					if (fail_count < MAX_SHOWN)
						$display("%0t: mismatch exp count %0d sat %0b, got count %0d sat %0b",
							$realtime, want.count, want.sat, corrected_count, saturated);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted word or result taken downstream
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_sums();
		test_extremes();
		test_rounding_and_saturation();
		test_random_frames(1000);
		test_random_noise(250);
		in_valid <= 1'b0;
		while (corrected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
